>>> hw/rtl/owts_pkg.sv
package owts_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_POST, PH_WR_LOW, PH_WR_HOLD, PH_WR_REC,
    PH_CONV, PH_RD_LOW, PH_RD_WAIT, PH_RD_REC, PH_RETRY
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW, REG_PRESENCE_WAIT, REG_POST_PRESENCE, REG_WRITE_SLOT,
    REG_READ_SAMPLE, REG_CONV_WAIT, REG_RETRY_LIMIT, REG_RETRY_DELAY
  } reg_index_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PRESENCE = 2'd1;
  localparam logic [1:0] ERR_CRC      = 2'd2;

  localparam logic [7:0] WR_LOW_TICKS = 8'd5;
  localparam logic [7:0] WR_REC_TICKS = 8'd2;
  localparam logic [7:0] RD_LOW_TICKS = 8'd3;
  localparam logic [7:0] RD_REC_TICKS = 8'd50;
  localparam logic [7:0] CRC_POLY     = 8'h8c;

  typedef struct packed {
    logic [11:0] reset_low;
    logic [11:0] presence_wait;
    logic [11:0] post_presence;
    logic [7:0]  write_slot;
    logic [7:0]  read_sample;
    logic [19:0] conv_wait;
    logic [2:0]  retry_limit;
    logic [19:0] retry_delay;
  } cfg_t;

  // Command byte for each write position: skip-ROM, convert, skip-ROM, read scratchpad.
  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    case (idx)
      2'd0: cmd_byte = 8'hcc;
      2'd1: cmd_byte = 8'h44;
      2'd2: cmd_byte = 8'hcc;
      default: cmd_byte = 8'hbe;
    endcase
  endfunction

  // Reflected CRC-8 over one byte, eight shift steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc8_byte = c;
  endfunction

endpackage

>>> hw/rtl/onewire_temp_read_sequencer.sv
// One-wire temperature read sequencer.
// Input channel (in_valid/in_stall): one item per bus tick, action 0 is a
// one-microsecond tick with the sampled line level, action 1 starts a read.
// Output channel (out_valid/out_stall): exactly one result per input item,
// carrying the line drive for that tick, busy and done flags, and the held
// temperature with its valid flag and error code.
// The result of an item is in the output register the cycle after its
// transfer. Throughput is one item per clock; the sequencer state and
// output registers update together in a single pass. When the receiver
// stalls a full output register, the input is stalled in the same cycle
// and nothing advances; the result holds steady. Configuration registers
// must be written through cfg_write/cfg_index/cfg_data while idle; the
// block does not check it. Synchronous reset loads default timings, clears
// the sequencer to idle with no valid temperature, and empties the output.
module onewire_temp_read_sequencer
  import owts_pkg::*;
#(
  parameter int SCRATCH_BYTES = 9,
  parameter int TICK_WIDTH    = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic        line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_release,
  output logic        busy_res,
  output logic        done_res,
  output logic        temp_valid,
  output logic signed [11:0] temperature,
  output logic [1:0]  error_code
);

  cfg_t        cfg;
  logic        step;
  logic [11:0] temp_bits;

  owts_cfg_regs u_cfg (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .cfg
  );

  // Output register drains or is empty: accept the next tick.
  assign in_stall = out_valid & out_stall;
  assign step     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  owts_seq #(.SCRATCH_BYTES(SCRATCH_BYTES), .TICK_WIDTH(TICK_WIDTH)) u_seq (
    .clk, .rst, .cfg, .step, .action, .line_level,
    .line_release, .busy_res, .done_res, .temp_valid,
    .temperature(temp_bits), .error_code
  );

  assign temperature = $signed(temp_bits);

endmodule

>>> hw/rtl/owts_cfg_regs.sv
module owts_cfg_regs
  import owts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output cfg_t        cfg
);

  // Register file of timing and retry settings.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low     <= 12'd500;
      cfg.presence_wait <= 12'd100;
      cfg.post_presence <= 12'd100;
      cfg.write_slot    <= 8'd55;
      cfg.read_sample   <= 8'd5;
      cfg.conv_wait     <= 20'd750000;
      cfg.retry_limit   <= 3'd3;
      cfg.retry_delay   <= 20'd500000;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_RESET_LOW:     cfg.reset_low     <= cfg_data[11:0];
        REG_PRESENCE_WAIT: cfg.presence_wait <= cfg_data[11:0];
        REG_POST_PRESENCE: cfg.post_presence <= cfg_data[11:0];
        REG_WRITE_SLOT:    cfg.write_slot    <= cfg_data[7:0];
        REG_READ_SAMPLE:   cfg.read_sample   <= cfg_data[7:0];
        REG_CONV_WAIT:     cfg.conv_wait     <= cfg_data[19:0];
        REG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[2:0];
        REG_RETRY_DELAY:   cfg.retry_delay   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/owts_seq.sv
module owts_seq
  import owts_pkg::*;
#(
  parameter int SCRATCH_BYTES = 9,
  parameter int TICK_WIDTH    = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic        action,
  input  logic        line_level,
  output logic        line_release,
  output logic        busy_res,
  output logic        done_res,
  output logic        temp_valid,
  output logic [11:0] temperature,
  output logic [1:0]  error_code
);

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
  localparam logic [3:0] LAST_BYTE = 4'(SCRATCH_BYTES);

  phase_t                phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [3:0]            byte_index, byte_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [7:0]            crc_accum, crc_accum_next;
  logic [15:0]           raw_word, raw_word_next;
  logic [2:0]            attempts_used, attempts_used_next;
  logic [11:0]           held_temperature, held_temperature_next;
  logic                  held_valid, held_valid_next;
  logic [1:0]            held_error, held_error_next;
  logic                  release_next, done_next;

  logic [23:0]           limit_raw;
  logic [TICK_WIDTH-1:0] limit, tick_inc;
  logic                  over;
  logic [2:0]            bit_inc;
  logic [3:0]            byte_inc;
  logic [2:0]            att_inc, lim_eff;
  logic [7:0]            crc_new, rd_shift;
  logic [15:0]           word_new;

  // Duration of the current phase, clipped to the counter and at least one.
  always_comb begin
    case (phase)
      PH_RST_LOW:  limit_raw = 24'(cfg.reset_low);
      PH_RST_WAIT: limit_raw = 24'(cfg.presence_wait);
      PH_POST:     limit_raw = 24'(cfg.post_presence);
      PH_WR_LOW:   limit_raw = 24'(WR_LOW_TICKS);
      PH_WR_HOLD:  limit_raw = 24'(cfg.write_slot);
      PH_WR_REC:   limit_raw = 24'(WR_REC_TICKS);
      PH_CONV:     limit_raw = 24'(cfg.conv_wait);
      PH_RD_LOW:   limit_raw = 24'(RD_LOW_TICKS);
      PH_RD_WAIT:  limit_raw = 24'(cfg.read_sample);
      PH_RD_REC:   limit_raw = 24'(RD_REC_TICKS);
      PH_RETRY:    limit_raw = 24'(cfg.retry_delay);
      default:     limit_raw = 24'd1;
    endcase
    if (limit_raw > 24'(TICK_MAX)) limit = TICK_MAX;
    else                           limit = limit_raw[TICK_WIDTH-1:0];
    if (limit == '0) limit = {{(TICK_WIDTH-1){1'b0}}, 1'b1};
    tick_inc = tick_count + 1'b1;
    over     = (tick_inc >= limit);
    bit_inc  = bit_index + 3'd1;
    byte_inc = byte_index + 4'd1;
    att_inc  = attempts_used + 3'd1;
    lim_eff  = (cfg.retry_limit == 3'd0) ? 3'd1 : cfg.retry_limit;
    rd_shift = {line_level, shift_byte[7:1]};
    crc_new  = crc8_byte(crc_accum, shift_byte);
    word_new = raw_word;
    if (byte_index == 4'd0) word_new[7:0]  = shift_byte;
    if (byte_index == 4'd1) word_new[15:8] = shift_byte;
  end

  // Next-state logic for one bus tick or command.
  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_index_next        = bit_index;
    byte_index_next       = byte_index;
    shift_byte_next       = shift_byte;
    crc_accum_next        = crc_accum;
    raw_word_next         = raw_word;
    attempts_used_next    = attempts_used;
    held_temperature_next = held_temperature;
    held_valid_next       = held_valid;
    held_error_next       = held_error;
    release_next          = 1'b1;
    done_next             = 1'b0;
    if (action) begin
      if (phase == PH_IDLE) begin
        attempts_used_next = '0;
        byte_index_next    = '0;
        phase_next         = PH_RST_LOW;
        tick_count_next    = '0;
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = over ? '0 : tick_inc;
      unique case (phase)
        PH_RST_LOW: begin
          release_next = 1'b0;
          if (over) phase_next = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (over) begin
            if (line_level) begin
              // Missing presence pulse.
              attempts_used_next = att_inc;
              if (att_inc >= lim_eff) begin
                held_valid_next = 1'b0;
                held_error_next = ERR_PRESENCE;
                phase_next      = PH_IDLE;
                done_next       = 1'b1;
              end else if (cfg.retry_delay == '0) begin
                byte_index_next = '0;
                phase_next      = PH_RST_LOW;
              end else begin
                phase_next = PH_RETRY;
              end
            end else if (cfg.post_presence == '0) begin
              bit_index_next  = '0;
              shift_byte_next = cmd_byte(byte_index[1:0]);
              phase_next      = PH_WR_LOW;
            end else begin
              phase_next = PH_POST;
            end
          end
        end
        PH_POST: begin
          if (over) begin
            bit_index_next  = '0;
            shift_byte_next = cmd_byte(byte_index[1:0]);
            phase_next      = PH_WR_LOW;
          end
        end
        PH_WR_LOW: begin
          release_next = 1'b0;
          if (over) phase_next = PH_WR_HOLD;
        end
        PH_WR_HOLD: begin
          release_next = shift_byte[0];
          if (over) phase_next = PH_WR_REC;
        end
        PH_WR_REC: begin
          if (over) begin
            shift_byte_next = shift_byte >> 1;
            bit_index_next  = bit_inc;
            if (bit_inc != 3'd0) begin
              phase_next = PH_WR_LOW;
            end else begin
              byte_index_next = byte_inc;
              if (byte_inc == 4'd2) begin
                phase_next = PH_CONV;
              end else if (byte_inc >= 4'd4) begin
                byte_index_next = '0;
                bit_index_next  = '0;
                shift_byte_next = '0;
                crc_accum_next  = '0;
                phase_next      = PH_RD_LOW;
              end else begin
                bit_index_next  = '0;
                shift_byte_next = cmd_byte(byte_inc[1:0]);
                phase_next      = PH_WR_LOW;
              end
            end
          end
        end
        PH_CONV: begin
          if (over) phase_next = PH_RST_LOW;
        end
        PH_RD_LOW: begin
          release_next = 1'b0;
          if (over) phase_next = PH_RD_WAIT;
        end
        PH_RD_WAIT: begin
          if (over) begin
            shift_byte_next = rd_shift;
            phase_next      = PH_RD_REC;
          end
        end
        PH_RD_REC: begin
          if (over) begin
            bit_index_next = bit_inc;
            if (bit_inc != 3'd0) begin
              phase_next = PH_RD_LOW;
            end else begin
              // End of a byte: fold into the CRC and capture the reading.
              crc_accum_next  = crc_new;
              raw_word_next   = word_new;
              byte_index_next = byte_inc;
              if (byte_inc >= LAST_BYTE) begin
                if (crc_new == 8'd0) begin
                  if ($signed(word_new) > 16'sd2047)
                    held_temperature_next = 12'h7ff;
                  else if ($signed(word_new) < -16'sd2048)
                    held_temperature_next = 12'h800;
                  else
                    held_temperature_next = word_new[11:0];
                  held_valid_next = 1'b1;
                  held_error_next = ERR_NONE;
                  phase_next      = PH_IDLE;
                  done_next       = 1'b1;
                end else begin
                  attempts_used_next = att_inc;
                  if (att_inc >= lim_eff) begin
                    held_valid_next = 1'b0;
                    held_error_next = ERR_CRC;
                    phase_next      = PH_IDLE;
                    done_next       = 1'b1;
                  end else if (cfg.retry_delay == '0) begin
                    byte_index_next = '0;
                    phase_next      = PH_RST_LOW;
                  end else begin
                    phase_next = PH_RETRY;
                  end
                end
              end else begin
                bit_index_next = '0;
                phase_next     = PH_RD_LOW;
              end
            end
          end
        end
        PH_RETRY: begin
          if (over) begin
            byte_index_next = '0;
            phase_next      = PH_RST_LOW;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // State and result registers advance once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      byte_index       <= '0;
      shift_byte       <= '0;
      crc_accum        <= '0;
      raw_word         <= '0;
      attempts_used    <= '0;
      held_temperature <= '0;
      held_valid       <= 1'b0;
      held_error       <= ERR_NONE;
      line_release     <= 1'b1;
      done_res         <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      byte_index       <= byte_index_next;
      shift_byte       <= shift_byte_next;
      crc_accum        <= crc_accum_next;
      raw_word         <= raw_word_next;
      attempts_used    <= attempts_used_next;
      held_temperature <= held_temperature_next;
      held_valid       <= held_valid_next;
      held_error       <= held_error_next;
      line_release     <= release_next;
      done_res         <= done_next;
    end
  end

  assign busy_res    = (phase != PH_IDLE);
  assign temp_valid  = held_valid;
  assign temperature = held_temperature;
  assign error_code  = held_error;

endmodule

>>> hw/rtl/owts_checker.sv
module owts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       busy_res,
  input logic       done_res,
  input logic       temp_valid,
  input logic [1:0] error_code
);

  // A finished sequence is never still busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res) else $error("done while busy");

  // A valid temperature never carries an error code.
  a_valid_noerr: assert property (@(posedge clk) disable iff (rst)
    out_valid && temp_valid |-> error_code == 2'd0) else $error("valid with error");

  // Each transfer in gives a result the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid) else $error("result missing");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(done_res)) else $error("result lost");

endmodule

bind onewire_temp_read_sequencer owts_checker u_owts_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .busy_res, .done_res, .temp_valid, .error_code
);
